@@ sv/psum_pkg.sv @@
package psum_pkg;

  // Mark store geometry
  localparam int unsigned MAX_LIMIT = 65536;
  localparam int unsigned MARK_DEPTH = MAX_LIMIT + 1;
  localparam int unsigned IDX_W = $clog2(MARK_DEPTH);
  // counters also hold limit + i, which reaches twice the limit
  localparam int unsigned CNT_W = IDX_W + 1;

  // Stream fields
  localparam int unsigned LIM_W = 17;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned IN_TDATA_W = 24;
  localparam int unsigned OUT_TDATA_W = 32;

  // Microprogram
  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] step_t;

  localparam step_t S_WAIT = 4'd0;
  localparam step_t S_CHK  = 4'd1;
  localparam step_t S_FILL = 4'd2;
  localparam step_t S_SET2 = 4'd3;
  localparam step_t S_RD   = 4'd4;
  localparam step_t S_TST  = 4'd5;
  localparam step_t S_PRM  = 4'd6;
  localparam step_t S_CLR  = 4'd7;
  localparam step_t S_NEXT = 4'd8;
  localparam step_t S_EMIT = 4'd9;
  localparam step_t S_BACK = 4'd10;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_ITEM,
    C_LIM_LT2,
    C_I_LT_LIM,
    C_MARK_CLR,
    C_J_LE_LIM,
    C_OUT_BUSY
  } cond_e;

  // which outcome of the jump lets the gated side effects through
  typedef enum logic [1:0] {
    G_NONE,
    G_TAKEN,
    G_FALL
  } gate_e;

  typedef enum logic [1:0] {
    I_KEEP,
    I_TWO,
    I_INC
  } iop_e;

  typedef enum logic [1:0] {
    J_KEEP,
    J_DBL,
    J_ADD
  } jop_e;

  typedef enum logic {
    A_I,
    A_J
  } asel_e;

  typedef struct packed {
    logic  in_ready;
    logic  ld_item;   // gated
    iop_e  i_op;
    jop_e  j_op;
    logic  sum_add;
    logic  mem_we;    // gated
    logic  mem_wbit;
    logic  mem_re;
    asel_e addr_sel;
    logic  out_load;  // gated
    gate_e gate;
    cond_e cond;
    step_t target;
  } cw_t;

  typedef struct packed {
    logic  in_ready;
    logic  ld_item;
    iop_e  i_op;
    jop_e  j_op;
    logic  sum_add;
    logic  mem_we;
    logic  mem_wbit;
    logic  mem_re;
    asel_e addr_sel;
    logic  out_load;
  } ctl_t;

  typedef struct packed {
    logic no_item;
    logic lim_lt2;
    logic i_lt_lim;
    logic mark_clr;
    logic j_le_lim;
    logic out_busy;
  } flags_t;

  function automatic cw_t cw_blank();
    cw_t c;
    c.in_ready = 1'b0;
    c.ld_item  = 1'b0;
    c.i_op     = I_KEEP;
    c.j_op     = J_KEEP;
    c.sum_add  = 1'b0;
    c.mem_we   = 1'b0;
    c.mem_wbit = 1'b0;
    c.mem_re   = 1'b0;
    c.addr_sel = A_I;
    c.out_load = 1'b0;
    c.gate     = G_NONE;
    c.cond     = C_ALWAYS;
    c.target   = S_WAIT;
    return c;
  endfunction

  // Control store: taken jump goes to target, otherwise to the next step
  function automatic cw_t ucode_rom(step_t pc);
    cw_t c;
    c = cw_blank();
    case (pc)
      S_WAIT: begin
        c.in_ready = 1'b1;
        c.ld_item  = 1'b1;
        c.gate     = G_FALL;
        c.cond     = C_NO_ITEM;
        c.target   = S_WAIT;
      end
      S_CHK: begin
        c.cond   = C_LIM_LT2;
        c.target = S_EMIT;
      end
      S_FILL: begin
        c.mem_we   = 1'b1;
        c.mem_wbit = 1'b1;
        c.addr_sel = A_I;
        c.i_op     = I_INC;
        c.cond     = C_I_LT_LIM;
        c.target   = S_FILL;
      end
      S_SET2: begin
        c.i_op   = I_TWO;
        c.target = S_RD;
      end
      S_RD: begin
        c.mem_re   = 1'b1;
        c.addr_sel = A_I;
        c.target   = S_TST;
      end
      S_TST: begin
        c.cond   = C_MARK_CLR;
        c.target = S_NEXT;
      end
      S_PRM: begin
        c.sum_add = 1'b1;
        c.j_op    = J_DBL;
        c.target  = S_CLR;
      end
      S_CLR: begin
        c.mem_we   = 1'b1;
        c.mem_wbit = 1'b0;
        c.addr_sel = A_J;
        c.j_op     = J_ADD;
        c.gate     = G_TAKEN;
        c.cond     = C_J_LE_LIM;
        c.target   = S_CLR;
      end
      S_NEXT: begin
        c.i_op   = I_INC;
        c.cond   = C_I_LT_LIM;
        c.target = S_RD;
      end
      S_EMIT: begin
        c.out_load = 1'b1;
        c.gate     = G_FALL;
        c.cond     = C_OUT_BUSY;
        c.target   = S_EMIT;
      end
      S_BACK: begin
        c.target = S_WAIT;
      end
      default: begin
        c.target = S_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

@@ sv/prime_sum_sieve_top.sv @@
// Sums all primes from 2 up to the limit carried by each input word (0 for a
// limit below two; limits above 65536 saturate to 65536), using a sieve of
// Eratosthenes over a single-port one-bit mark store. One word is processed
// at a time. For a limit N >= 2 the sequencer first sets the marks of 2..N,
// then scans each index from 2 to N: a composite index is passed over, and
// a prime is added to the sum and its multiples up to N are cleared; then
// the result is posted. The mark store does one read or one write per cycle,
// and the microcoded sequencer issues those accesses. A limit below two
// skips the sieve and posts zero. The result sits in an output register, so
// the next word is taken while it waits to be read.
module prime_sum_sieve_top
  import psum_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [16:0] upper_limit
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // [31:0] prime_total
);

  ctl_t   ctl;
  flags_t flags;

  logic [CNT_W-1:0]   limit_q, limit_d;
  logic [CNT_W-1:0]   i_q, i_d;
  logic [CNT_W-1:0]   j_q, j_d;
  logic [TOTAL_W-1:0] sum_q, sum_d;
  logic [TOTAL_W-1:0] out_data_q, out_data_d;
  logic               out_valid_q, out_valid_d;

  logic [LIM_W-1:0]   lim_in;
  logic [CNT_W-1:0]   lim_sat;
  logic [IDX_W-1:0]   mem_addr;
  logic               rd_q;
  logic               mark_mem [MARK_DEPTH];

  psum_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  assign s_axis_tready_o = ctl.in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign lim_in  = s_axis_tdata_i[LIM_W-1:0];
  assign lim_sat = (32'(lim_in) > 32'(MAX_LIMIT)) ? CNT_W'(MAX_LIMIT) : CNT_W'(lim_in);

  always_comb begin
    flags.no_item  = ~(s_axis_tvalid_i & ctl.in_ready);
    flags.lim_lt2  = limit_q < CNT_W'(2);
    flags.i_lt_lim = i_q < limit_q;
    flags.mark_clr = ~rd_q;
    flags.j_le_lim = j_q <= limit_q;
    flags.out_busy = out_valid_q & ~m_axis_tready_i;
  end

  always_comb begin
    limit_d = limit_q;
    i_d     = i_q;
    j_d     = j_q;
    sum_d   = sum_q;

    case (ctl.i_op)
      I_TWO:   i_d = CNT_W'(2);
      I_INC:   i_d = i_q + CNT_W'(1);
      default: i_d = i_q;
    endcase

    case (ctl.j_op)
      J_DBL:   j_d = i_q + i_q;
      J_ADD:   j_d = j_q + i_q;
      default: j_d = j_q;
    endcase

    if (ctl.sum_add) begin
      sum_d = sum_q + TOTAL_W'(i_q);
    end

    if (ctl.ld_item) begin
      limit_d = lim_sat;
      i_d     = CNT_W'(2);
      sum_d   = '0;
    end
  end

  always_comb begin
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    if (ctl.out_load) begin
      out_data_d  = sum_q;
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q    <= limit_d;
    i_q        <= i_d;
    j_q        <= j_d;
    sum_q      <= sum_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // single port: one read or one write per cycle
  assign mem_addr = (ctl.addr_sel == A_J) ? j_q[IDX_W-1:0] : i_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl.mem_we) begin
      mark_mem[mem_addr] <= ctl.mem_wbit;
    end
    if (ctl.mem_re) begin
      rd_q <= mark_mem[mem_addr];
    end
  end

endmodule

@@ sv/psum_seq.sv @@
module psum_seq
  import psum_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ctl_t   ctl_o
);

  step_t pc_q, pc_d;
  cw_t   cw;
  logic  taken;
  logic  pass;

  assign cw = ucode_rom(pc_q);

  always_comb begin
    case (cw.cond)
      C_ALWAYS:   taken = 1'b1;
      C_NO_ITEM:  taken = flags_i.no_item;
      C_LIM_LT2:  taken = flags_i.lim_lt2;
      C_I_LT_LIM: taken = flags_i.i_lt_lim;
      C_MARK_CLR: taken = flags_i.mark_clr;
      C_J_LE_LIM: taken = flags_i.j_le_lim;
      C_OUT_BUSY: taken = flags_i.out_busy;
      default:    taken = 1'b1;
    endcase
  end

  always_comb begin
    case (cw.gate)
      G_NONE:  pass = 1'b1;
      G_TAKEN: pass = taken;
      G_FALL:  pass = ~taken;
      default: pass = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = taken ? cw.target : pc_q + step_t'(1);
  end

  always_comb begin
    ctl_o.in_ready = cw.in_ready;
    ctl_o.ld_item  = cw.ld_item & pass;
    ctl_o.i_op     = cw.i_op;
    ctl_o.j_op     = cw.j_op;
    ctl_o.sum_add  = cw.sum_add;
    ctl_o.mem_we   = cw.mem_we & pass;
    ctl_o.mem_wbit = cw.mem_wbit;
    ctl_o.mem_re   = cw.mem_re;
    ctl_o.addr_sel = cw.addr_sel;
    ctl_o.out_load = cw.out_load & pass;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
